// ===== rtl/core/crc16fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame checker.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

    localparam logic [15:0] CRC_POLY     = 16'h8408;
    localparam logic [15:0] CRC_INIT     = 16'h0000;
    localparam logic [15:0] CRC_EMPTY    = 16'hFFFF;
    localparam logic [1:0]  HELD_NONE    = 2'd0;
    localparam logic [1:0]  HELD_ONE     = 2'd1;
    localparam logic [1:0]  HELD_TWO     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] crc_value;
        logic        crc_match;
        logic        frame_too_short;
    } result_item_t;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        mix;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ data[i];
            c   = {1'b0, c[15:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc16_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_checker_core
// Checks the reflected CRC-16 trailer (poly 0x8408, init 0, inverted) of a
// byte-serial frame and reports CRC, match and too-short flags per frame.
//
//   channel   direction  payload        transfer when
//   byte      in         byte_item_t    byte_valid && !byte_stall
//   result    out        result_item_t  result_valid && !result_stall
//
// One byte is taken every cycle unless the input stalls; the CRC update is one unrolled 8-bit step.
// A frame result appears in the output register the cycle after its final
// byte. Input stalls only while a result is held and the result side stalls.
// Reset clears the delay, the running CRC and the output valid.
// ----------------------------------------------------------------------------
module crc16_frame_checker_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  crc16fc_pkg::byte_item_t    byte_item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output crc16fc_pkg::result_item_t  result_item
);

    logic                      take;
    logic                      fire;
    logic                      busy;
    crc16fc_pkg::result_item_t frame_result;

    assign byte_stall = busy;
    assign take       = byte_valid && !busy;

    crc16fc_frame_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (byte_item),
        .fire   (fire),
        .result (frame_result)
    );

    crc16fc_result_reg u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .load_item    (frame_result),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== rtl/core/crc16fc_frame_track.sv =====
// ----------------------------------------------------------------------------
// crc16fc_frame_track
// Two-byte holdback delay and running CRC; forms the frame result on the
// final byte and clears for the next frame.
// ----------------------------------------------------------------------------
module crc16fc_frame_track (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  crc16fc_pkg::byte_item_t    item,
    output logic                       fire,
    output crc16fc_pkg::result_item_t  result
);

    logic [15:0] crc_reg,   crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [1:0]  count_reg, count_next;
    logic [15:0] crc_fold;
    logic [15:0] crc_inv;

    assign crc_fold = crc16fc_pkg::crc_byte(crc_reg, held0_reg);
    assign crc_inv  = ~crc_fold;

    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        if (take)
        begin
            if (item.frame_end)
            begin
                crc_next   = crc16fc_pkg::CRC_INIT;
                held0_next = 8'd0;
                held1_next = 8'd0;
                count_next = crc16fc_pkg::HELD_NONE;
            end
            else if (count_reg == crc16fc_pkg::HELD_TWO)
            begin
                // advance: oldest held byte leaves the delay into the CRC
                crc_next   = crc_fold;
                held0_next = held1_reg;
                held1_next = item.data_byte;
            end
            else if (count_reg == crc16fc_pkg::HELD_NONE)
            begin
                held0_next = item.data_byte;
                count_next = crc16fc_pkg::HELD_ONE;
            end
            else
            begin
                held1_next = item.data_byte;
                count_next = crc16fc_pkg::HELD_TWO;
            end
        end
    end

    always_comb
    begin
        fire = take && item.frame_end;
        if (count_reg != crc16fc_pkg::HELD_TWO)
        begin
            result.crc_value       = crc16fc_pkg::CRC_EMPTY;
            result.crc_match       = 1'b0;
            result.frame_too_short = 1'b1;
        end
        else
        begin
            result.crc_value       = crc_inv;
            result.crc_match       = (crc_inv == {item.data_byte, held1_reg});
            result.frame_too_short = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= crc16fc_pkg::CRC_INIT;
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
            count_reg <= crc16fc_pkg::HELD_NONE;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/crc16fc_result_reg.sv =====
// ----------------------------------------------------------------------------
// crc16fc_result_reg
// Output register for frame results; holds a result until its transfer.
// ----------------------------------------------------------------------------
module crc16fc_result_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  crc16fc_pkg::result_item_t  load_item,
    output logic                       busy,
    output logic                       result_valid,
    input  logic                       result_stall,
    output crc16fc_pkg::result_item_t  result_item
);

    logic                      valid_reg, valid_next;
    crc16fc_pkg::result_item_t item_reg,  item_next;

    // hold off upstream only while a result sits here and is being stalled
    assign busy         = valid_reg && result_stall;
    assign result_valid = valid_reg;
    assign result_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next = 1'b1;
            item_next  = load_item;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Frame-level check of crc16_frame_checker_core: byte frames with good,
// corrupted and short trailers are streamed through the byte channel, and
// each frame result is compared with a local CRC-16 trailer predictor.
// Throttling differs over three traffic phases; the last one throttles neither side.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [7:0] byte_list_t[$];

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      byte_valid   = 1'b0;
    logic                      byte_stall;
    crc16fc_pkg::byte_item_t   byte_item    = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    crc16fc_pkg::result_item_t result_item;

    crc16_frame_checker_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #2 clk = ~clk;

    // Pending stimulus and the frame results it is expected to produce
    crc16fc_pkg::byte_item_t   pending_bytes[$];
    crc16fc_pkg::result_item_t frame_results[$];

    int unsigned total_bytes   = 0;
    int unsigned bytes_sent    = 0;
    int unsigned traffic_phase = 0;
    int unsigned mismatch_count = 0;
    int unsigned frames_seen   = 0;
    int unsigned short_seen    = 0;
    int unsigned match_seen    = 0;

    // Predictor state: CRC over bytes out of the delay, two-byte delay, fill count
    logic [15:0] crc_acc   = crc16fc_pkg::CRC_INIT;
    logic [7:0]  delay_q[2] = '{8'h00, 8'h00};
    logic [1:0]  delay_cnt = crc16fc_pkg::HELD_NONE;

    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ crc16fc_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic int unsigned tx_idle_pct(input int unsigned phase);
        return (phase == 0) ? 6 : (phase == 1) ? 63 : 0;
    endfunction

    function automatic int unsigned rx_idle_pct(input int unsigned phase);
        return (phase == 0) ? 63 : (phase == 1) ? 6 : 0;
    endfunction

    task automatic predict_byte(input crc16fc_pkg::byte_item_t it);
        crc16fc_pkg::result_item_t r;
        logic [15:0]               inv;
        if (!it.frame_end)
        begin
            if (delay_cnt == crc16fc_pkg::HELD_TWO)
            begin
                // advance the delay: oldest byte goes into the CRC
                crc_acc    = crc16_fold(crc_acc, delay_q[0]);
                delay_q[0] = delay_q[1];
                delay_q[1] = it.data_byte;
            end
            else
            begin
                delay_q[delay_cnt[0]] = it.data_byte;
                delay_cnt = delay_cnt + 2'd1;
            end
        end
        else
        begin
            if (delay_cnt != crc16fc_pkg::HELD_TWO)
            begin
                r.crc_value       = crc16fc_pkg::CRC_EMPTY;
                r.crc_match       = 1'b0;
                r.frame_too_short = 1'b1;
            end
            else
            begin
                inv = ~crc16_fold(crc_acc, delay_q[0]);
                r.crc_value       = inv;
                r.crc_match       = (inv == {it.data_byte, delay_q[1]});
                r.frame_too_short = 1'b0;
            end
            frame_results.push_back(r);
            crc_acc    = crc16fc_pkg::CRC_INIT;
            delay_q[0] = 8'h00;
            delay_q[1] = 8'h00;
            delay_cnt  = crc16fc_pkg::HELD_NONE;
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        crc16fc_pkg::byte_item_t it;
        it.data_byte = data;
        it.frame_end = last;
        pending_bytes.push_back(it);
    endtask

    // Payload followed by its little-endian trailer; corrupt flips one trailer bit
    task automatic add_frame(input byte_list_t payload, input bit corrupt);
        logic [15:0] c;
        c = crc16fc_pkg::CRC_INIT;
        foreach (payload[i])
        begin
            c = crc16_fold(c, payload[i]);
            push_byte(payload[i], 1'b0);
        end
        c = ~c;
        if (corrupt)
        begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        push_byte(c[7:0], 1'b0);
        push_byte(c[15:8], 1'b1);
    endtask

    function automatic logic [7:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_mismatch(input string what, input crc16fc_pkg::result_item_t want,
                                 input crc16fc_pkg::result_item_t got);
        if (mismatch_count < 10)
        begin
            $display("%s: expected crc=%h match=%b short=%b, got crc=%h match=%b short=%b",
                     what, want.crc_value, want.crc_match, want.frame_too_short,
                     got.crc_value, got.crc_match, got.frame_too_short);
        end
        mismatch_count++;
    endtask

    // Byte driver: hold a stalled transfer, otherwise offer the next byte or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                predict_byte(byte_item);
                bytes_sent++;
            end
            traffic_phase <= (total_bytes == 0) ? 2 : (bytes_sent * 3) / total_bytes;
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() != 0 &&
                    $urandom_range(0, 99) >= tx_idle_pct(traffic_phase))
                begin
                    byte_valid <= 1'b1;
                    byte_item  <= pending_bytes.pop_front();
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < rx_idle_pct(traffic_phase));
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : result_monitor
        crc16fc_pkg::result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (frame_results.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected result", want, result_item);
            end
            else
            begin
                want = frame_results.pop_front();
                frames_seen++;
                if (want.frame_too_short)
                begin
                    short_seen++;
                end
                if (want.crc_match)
                begin
                    match_seen++;
                end
                if (result_item.crc_value !== want.crc_value ||
                    result_item.crc_match !== want.crc_match ||
                    result_item.frame_too_short !== want.frame_too_short)
                begin
                    note_mismatch("result mismatch", want, result_item);
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned len;
        byte_list_t  payload;

        // single-byte and two-byte frames
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        // shortest checked frame, good and bad trailer
        add_frame('{8'h00}, 1'b0);
        add_frame('{8'hFF}, 1'b1);
        // all-zero trailer, all-ones trailer
        push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        add_frame('{8'hFF, 8'h00, 8'hA5, 8'h5A}, 1'b0);

        while (pending_bytes.size() < 400)
        begin
            pick = $urandom_range(0, 99);
            payload.delete();
            if (pick < 82)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
                                                   : $urandom_range(1, 8);
                repeat (len) payload.push_back(rand_byte());
                add_frame(payload, pick >= 70);
            end
            else if (pick < 92)
            begin
                if ($urandom_range(0, 1))
                begin
                    push_byte(rand_byte(), 1'b0);
                end
                push_byte(rand_byte(), 1'b1);
            end
            else
            begin
                // noise frame: random bytes, random trailer
                len = $urandom_range(3, 10);
                repeat (len - 1) push_byte(rand_byte(), 1'b0);
                push_byte(rand_byte(), 1'b1);
            end
        end
        total_bytes = pending_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_sent == total_bytes);
        for (int i = 0; i < 4000 && frame_results.size() != 0; i++)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (frame_results.size() != 0)
        begin
            $display("%0d frame results never arrived", frame_results.size());
            mismatch_count += frame_results.size();
        end

        $display("covered %0d bytes in %0d frames: %0d short, %0d with matching trailer",
                 total_bytes, frames_seen, short_seen, match_seen);
        $display("%0d mismatches over three throttling phases", mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin : watchdog
        #400000;
        $display("timeout waiting for transfers");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
